FILE: sv/btins_pkg.sv
package btins_pkg;

  localparam int KeyW    = 32;
  localparam int ValW    = 32;
  localparam int LeafCntW = 11;
  localparam int InnerCntW = 10;
  localparam int HeightW  = 6;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DUP   = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  typedef struct packed {
    logic            command;
    logic [KeyW-1:0] key;
    logic [ValW-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [KeyW-1:0]      match_key;
    logic [ValW-1:0]      match_value;
    logic [LeafCntW-1:0]  leaf_count;
    logic [InnerCntW-1:0] internal_count;
    logic [HeightW-1:0]   tree_height;
  } out_word_t;

endpackage

FILE: sv/btins_pool.sv
// Node pool: links, leaf flag, key and value per node, registered read.
module btins_pool #(
  parameter int NODE_DEPTH = 1024,
  parameter int KEY_BITS   = 32,
  parameter int IW         = 10,
  parameter int LW         = 11
) (
  input  logic                clk,
  input  logic [IW-1:0]       rd_addr,
  output logic [LW-1:0]       rd_link0,
  output logic [LW-1:0]       rd_link1,
  output logic                rd_leaf,
  output logic [KEY_BITS-1:0] rd_key,
  output logic [31:0]         rd_value,
  input  logic                wr_en,
  input  logic [IW-1:0]       wr_addr,
  input  logic [LW-1:0]       wr_link0,
  input  logic [LW-1:0]       wr_link1,
  input  logic                wr_leaf,
  input  logic [KEY_BITS-1:0] wr_key,
  input  logic [31:0]         wr_value
);
  localparam int EW = 2*LW + 1 + KEY_BITS + 32;

  logic [EW-1:0] mem [NODE_DEPTH];
  logic [EW-1:0] rd_r;

  // write one node, read one node
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_link0, wr_link1, wr_leaf, wr_key, wr_value};
    end
    rd_r <= mem[rd_addr];
  end

  assign {rd_link0, rd_link1, rd_leaf, rd_key, rd_value} = rd_r;
endmodule

FILE: sv/binary_trie_insert_nearest_search_unit.sv
// Channel  | Ports                      | Handshake
// input    | start, busy, in_word       | taken when start && !busy
// result   | out_valid, out_word        | one-cycle strobe, always taken
//
// Each word walks the trie one node per memory read; every level steps through
// read issue, data and decide states, and a walk spans up to 33 levels.
// An insert that splits a leaf first counts shared bits to check for room,
// then per pushed level writes a leaf copy and relinks the node, and writes
// the new leaf in S_DONE. busy is high from acceptance until the result
// strobe; the receiver cannot stall. Reset is synchronous, active low, and
// clears the control state, counters and root only; the pool needs no clearing.
module binary_trie_insert_nearest_search_unit #(
  parameter int NODE_DEPTH = 1024
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  btins_pkg::in_word_t  in_word,
  output logic                 out_valid,
  output btins_pkg::out_word_t out_word
);
  import btins_pkg::*;

  localparam int IW = (NODE_DEPTH > 1) ? $clog2(NODE_DEPTH) : 1;
  localparam int LW = $clog2(NODE_DEPTH + 1);
  localparam int BW = $clog2(KeyW + 1);
  localparam int KIW = $clog2(KeyW);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_RD     = 10'b0000000010,
    S_WAIT   = 10'b0000000100,
    S_DEC    = 10'b0000001000,
    S_CNT    = 10'b0000010000,
    S_PUSH   = 10'b0000100000,
    S_SRCHRD = 10'b0001000000,
    S_SRCHW  = 10'b0010000000,
    S_SRCHD  = 10'b0100000000,
    S_DONE   = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [LW-1:0] next_free_r, next_free_nxt;
  logic [LW-1:0] stored_r, stored_nxt;
  logic [LW-1:0] inner_r, inner_nxt;
  logic [HeightW-1:0] levels_r, levels_nxt;
  logic [IW-1:0] root_r, root_nxt;
  // trailing leaf write after the split relink
  logic          tail_r, tail_nxt;

  logic                cmd_r;
  logic [KeyW-1:0]     key_r;
  logic [31:0]         val_r;
  logic [IW-1:0]       node_r, node_nxt;
  logic [LW-1:0]       depth_r, depth_nxt;
  logic [BW-1:0]       bit_r, bit_nxt;     // bit index plus one
  logic [BW-1:0]       pbit_r, pbit_nxt;
  logic [LW:0]         push_r, push_nxt;
  logic [1:0]          mode_r, mode_nxt;
  logic [KeyW-1:0]     okey_r, okey_nxt;
  logic [31:0]         oval_r, oval_nxt;
  logic [1:0]          st_r, st_nxt;
  logic [KeyW-1:0]     mk_r, mk_nxt;
  logic [ValW-1:0]     mv_r, mv_nxt;

  logic [IW-1:0]       rd_addr;
  logic [LW-1:0]       rd_l0, rd_l1;
  logic                rd_leaf;
  logic [KeyW-1:0]     rd_key;
  logic [31:0]         rd_val;
  logic                wr_en;
  logic [IW-1:0]       wr_addr;
  logic [LW-1:0]       wr_l0, wr_l1;
  logic                wr_leaf;
  logic [KeyW-1:0]     wr_key;
  logic [31:0]         wr_val;

  btins_pool #(.NODE_DEPTH(NODE_DEPTH), .KEY_BITS(KeyW), .IW(IW), .LW(LW)) u_pool (
    .clk(clk), .rd_addr(rd_addr), .rd_link0(rd_l0), .rd_link1(rd_l1),
    .rd_leaf(rd_leaf), .rd_key(rd_key), .rd_value(rd_val),
    .wr_en(wr_en), .wr_addr(wr_addr), .wr_link0(wr_l0), .wr_link1(wr_l1),
    .wr_leaf(wr_leaf), .wr_key(wr_key), .wr_value(wr_val)
  );

  logic [BW-1:0] bi;
  logic          kb, ob, ib;
  logic [LW-1:0] cl;
  logic [LW:0]   room;
  logic [LW:0]   free_ext;

  assign busy = (state_r != S_IDLE);
  assign rd_addr = node_r;
  assign free_ext = {1'b0, next_free_r};

  // sequencer
  always_comb begin
    state_nxt = state_r;
    next_free_nxt = next_free_r;
    stored_nxt = stored_r;
    inner_nxt = inner_r;
    levels_nxt = levels_r;
    root_nxt = root_r;
    tail_nxt = 1'b0;
    node_nxt = node_r;
    depth_nxt = depth_r;
    bit_nxt = bit_r;
    pbit_nxt = pbit_r;
    push_nxt = push_r;
    mode_nxt = mode_r;
    okey_nxt = okey_r;
    oval_nxt = oval_r;
    st_nxt = st_r;
    mk_nxt = mk_r;
    mv_nxt = mv_r;
    wr_en = 1'b0;
    wr_addr = next_free_r[IW-1:0];
    wr_l0 = '0;
    wr_l1 = '0;
    wr_leaf = 1'b1;
    wr_key = key_r;
    wr_val = val_r;
    bi = bit_r - BW'(1);
    kb = key_r[bi[KIW-1:0]];
    ob = okey_r[bi[KIW-1:0]];
    ib = (mode_r == 2'd0) ? kb : mode_r[1];
    cl = ib ? rd_l1 : rd_l0;
    room = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          st_nxt = ST_OK;
          mk_nxt = '0;
          mv_nxt = '0;
          node_nxt = root_r;
          depth_nxt = LW'(1);
          bit_nxt = BW'(KeyW);
          mode_nxt = 2'd0;
          if (in_word.command == CMD_SEARCH) begin
            if (stored_r == '0) begin
              st_nxt = ST_EMPTY;
              state_nxt = S_DONE;
            end else begin
              state_nxt = S_SRCHRD;
            end
          end else if (stored_r == '0) begin
            if (free_ext + (LW+1)'(1) > (LW+1)'(NODE_DEPTH)) begin
              st_nxt = ST_FULL;
              state_nxt = S_DONE;
            end else begin
              // first key becomes the root
              wr_en = 1'b1;
              wr_key = in_word.key;
              wr_val = in_word.value;
              root_nxt = next_free_r[IW-1:0];
              next_free_nxt = next_free_r + LW'(1);
              stored_nxt = LW'(1);
              if (levels_r < HeightW'(1)) levels_nxt = HeightW'(1);
              state_nxt = S_DONE;
            end
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      S_RD, S_SRCHRD: begin
        if ({1'b0, node_r} >= free_ext) begin
          st_nxt = (state_r == S_RD) ? ST_DUP : ST_EMPTY;
          state_nxt = S_DONE;
        end else begin
          state_nxt = (state_r == S_RD) ? S_WAIT : S_SRCHW;
        end
      end
      S_WAIT: state_nxt = S_DEC;
      S_SRCHW: state_nxt = S_SRCHD;
      S_DEC: begin
        if (rd_leaf) begin
          okey_nxt = rd_key;
          oval_nxt = rd_val;
          if (rd_key == key_r || bit_r == '0) begin
            st_nxt = ST_DUP;
            state_nxt = S_DONE;
          end else begin
            pbit_nxt = bit_r;
            push_nxt = '0;
            state_nxt = S_CNT;
          end
        end else if (bit_r == '0) begin
          st_nxt = ST_DUP;
          state_nxt = S_DONE;
        end else if (cl == '0) begin
          if (free_ext + (LW+1)'(1) > (LW+1)'(NODE_DEPTH)) begin
            st_nxt = ST_FULL;
            state_nxt = S_DONE;
          end else begin
            // new leaf, then relink the parent
            wr_en = 1'b1;
            next_free_nxt = next_free_r + LW'(1);
            okey_nxt = '0;
            oval_nxt = '0;
            pbit_nxt = '0;
            push_nxt = {1'b0, next_free_r};
            state_nxt = S_PUSH;
          end
        end else begin
          node_nxt = IW'(cl - LW'(1));
          depth_nxt = depth_r + LW'(1);
          bit_nxt = bit_r - BW'(1);
          state_nxt = S_RD;
        end
      end
      S_CNT: begin
        // count shared bits one per cycle
        push_nxt = push_r + (LW+1)'(1);
        if (kb != ob) begin
          room = free_ext + push_r + (LW+1)'(2);
          if (room > (LW+1)'(NODE_DEPTH)) begin
            st_nxt = ST_FULL;
            state_nxt = S_DONE;
          end else begin
            bit_nxt = pbit_r;
            state_nxt = S_PUSH;
            push_nxt = '1;
          end
        end else begin
          bit_nxt = bit_r - BW'(1);
        end
      end
      S_PUSH: begin
        if (pbit_r == '0) begin
          // link parent to the new leaf placed at push_r
          wr_en = 1'b1;
          wr_addr = node_r;
          wr_leaf = 1'b0;
          wr_l0 = kb ? rd_l0 : LW'(push_r + 1'b1);
          wr_l1 = kb ? LW'(push_r + 1'b1) : rd_l1;
          if ({1'b0, levels_r} < depth_r + LW'(1)) levels_nxt = HeightW'(depth_r + LW'(1));
          stored_nxt = stored_r + LW'(1);
          state_nxt = S_DONE;
        end else if (push_r == '1) begin
          // write the old leaf copy one level down
          wr_en = 1'b1;
          wr_key = okey_r;
          wr_val = oval_r;
          push_nxt = {1'b0, next_free_r};
          next_free_nxt = next_free_r + LW'(1);
        end else begin
          // turn node into internal, child on old bit
          wr_en = 1'b1;
          wr_addr = node_r;
          wr_leaf = 1'b0;
          wr_l0 = ob ? '0 : LW'(push_r + 1'b1);
          wr_l1 = ob ? LW'(push_r + 1'b1) : '0;
          inner_nxt = inner_r + LW'(1);
          if (kb != ob) begin
            wr_l0 = ob ? LW'(next_free_r + LW'(1)) : LW'(push_r + 1'b1);
            wr_l1 = ob ? LW'(push_r + 1'b1) : LW'(next_free_r + LW'(1));
            okey_nxt = key_r;
            oval_nxt = val_r;
            push_nxt = '1;
            pbit_nxt = '0;
            if ({1'b0, levels_r} < depth_r + LW'(1)) levels_nxt = HeightW'(depth_r + LW'(1));
            stored_nxt = stored_r + LW'(1);
            tail_nxt = 1'b1;
            state_nxt = S_DONE;
          end else begin
            node_nxt = push_r[IW-1:0];
            depth_nxt = depth_r + LW'(1);
            bit_nxt = bit_r - BW'(1);
            push_nxt = '1;
          end
        end
      end
      S_SRCHD: begin
        if (rd_leaf) begin
          mk_nxt = rd_key;
          mv_nxt = rd_val;
          state_nxt = S_DONE;
        end else if (bit_r == '0) begin
          st_nxt = ST_EMPTY;
          state_nxt = S_DONE;
        end else begin
          if (cl == '0) begin
            cl = ib ? rd_l0 : rd_l1;
            if (mode_r == 2'd0) mode_nxt = kb ? 2'd2 : 2'd1;
          end
          if (cl == '0) begin
            st_nxt = ST_EMPTY;
            state_nxt = S_DONE;
          end else begin
            node_nxt = IW'(cl - LW'(1));
            bit_nxt = bit_r - BW'(1);
            state_nxt = S_SRCHRD;
          end
        end
      end
      S_DONE: begin
        // place the new leaf beside the split node
        if (tail_r) begin
          wr_en = 1'b1;
          next_free_nxt = next_free_r + LW'(1);
        end
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // advance control state and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      next_free_r <= '0;
      stored_r <= '0;
      inner_r <= '0;
      levels_r <= '0;
      root_r <= '0;
      out_valid <= 1'b0;
      tail_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      next_free_r <= next_free_nxt;
      stored_r <= stored_nxt;
      inner_r <= inner_nxt;
      levels_r <= levels_nxt;
      root_r <= root_nxt;
      out_valid <= (state_r == S_DONE);
      tail_r <= tail_nxt;
    end
  end

  // hold the word and walk registers
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start) begin
      cmd_r <= in_word.command;
      key_r <= in_word.key;
      val_r <= in_word.value;
    end
    node_r <= node_nxt;
    depth_r <= depth_nxt;
    bit_r <= bit_nxt;
    pbit_r <= pbit_nxt;
    push_r <= push_nxt;
    mode_r <= mode_nxt;
    okey_r <= okey_nxt;
    oval_r <= oval_nxt;
    st_r <= st_nxt;
    mk_r <= mk_nxt;
    mv_r <= mv_nxt;
  end

  // drive the result word
  always_comb begin
    out_word.status = st_r;
    out_word.match_key = (cmd_r == CMD_SEARCH) ? mk_r : '0;
    out_word.match_value = (cmd_r == CMD_SEARCH) ? mv_r : '0;
    out_word.leaf_count = LeafCntW'(stored_r);
    out_word.internal_count = InnerCntW'(inner_r);
    out_word.tree_height = levels_r;
  end
endmodule

FILE: dv/binary_trie_insert_nearest_search_unit_checker.sv
`timescale 1ns / 1ps

module binary_trie_insert_nearest_search_unit_checker (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 busy,
  input  btins_pkg::in_word_t  in_word,
  input  logic                 out_valid,
  input  btins_pkg::out_word_t out_word,
  output int                   mismatches,
  output int                   replies_owed
);
  import btins_pkg::*;

  localparam int PoolSize = 1024;

  // Shadow node pool: links hold child index plus one, zero for no child
  int unsigned      link_lo [PoolSize];
  int unsigned      link_hi [PoolSize];
  bit               is_leaf [PoolSize];
  logic [KeyW-1:0]  node_key [PoolSize];
  logic [ValW-1:0]  node_val [PoolSize];
  int unsigned      root_node;
  int unsigned      nodes_used;
  int unsigned      leaf_total;
  int unsigned      inner_total;
  int unsigned      depth_max;

  out_word_t trie_replies[$];

  initial begin
    mismatches = 0;
    replies_owed = 0;
    root_node = 0;
    nodes_used = 0;
    leaf_total = 0;
    inner_total = 0;
    depth_max = 0;
    for (int i = 0; i < PoolSize; i++) begin
      link_lo[i] = 0;
      link_hi[i] = 0;
      is_leaf[i] = 0;
      node_key[i] = '0;
      node_val[i] = '0;
    end
  end

  function automatic int unsigned alloc_leaf(logic [KeyW-1:0] k, logic [ValW-1:0] v);
    int unsigned idx;
    idx = nodes_used;
    nodes_used++;
    is_leaf[idx] = 1;
    node_key[idx] = k;
    node_val[idx] = v;
    link_lo[idx] = 0;
    link_hi[idx] = 0;
    return idx;
  endfunction

  function automatic void set_link(int unsigned n, bit side, int unsigned c);
    if (side) link_hi[n] = c;
    else link_lo[n] = c;
  endfunction

  function automatic void grow_depth(int unsigned d);
    if (d > depth_max) depth_max = d;
  endfunction

  function automatic logic [1:0] trie_insert(logic [KeyW-1:0] k, logic [ValW-1:0] v);
    int unsigned n, d, pushes, m, t, c;
    int i, j;
    bit ob, nb;
    if (leaf_total == 0) begin
      if (nodes_used + 1 > PoolSize) return ST_FULL;
      root_node = alloc_leaf(k, v);
      leaf_total = 1;
      grow_depth(1);
      return ST_OK;
    end
    n = root_node;
    d = 1;
    i = KeyW - 1;
    forever begin
      if (n >= nodes_used) return ST_DUP;
      if (is_leaf[n]) begin
        if (node_key[n] == k) return ST_DUP;
        // count the levels the two keys share, plus the one where they part
        pushes = 0;
        for (j = i; j >= 0; j--) begin
          pushes++;
          if (k[j] != node_key[n][j]) break;
        end
        if (j < 0) return ST_DUP;
        if (nodes_used + pushes + 1 > PoolSize) return ST_FULL;
        // push the old leaf down until the bits differ
        for (j = i; j >= 0; j--) begin
          ob = node_key[n][j];
          nb = k[j];
          m = alloc_leaf(node_key[n], node_val[n]);
          is_leaf[n] = 0;
          link_lo[n] = 0;
          link_hi[n] = 0;
          set_link(n, ob, m + 1);
          inner_total++;
          if (nb != ob) begin
            t = alloc_leaf(k, v);
            set_link(n, nb, t + 1);
            grow_depth(d + 1);
            leaf_total++;
            return ST_OK;
          end
          n = m;
          d++;
        end
        return ST_DUP;
      end
      if (i < 0) return ST_DUP;
      c = k[i] ? link_hi[n] : link_lo[n];
      if (c == 0) begin
        if (nodes_used + 1 > PoolSize) return ST_FULL;
        t = alloc_leaf(k, v);
        set_link(n, k[i], t + 1);
        grow_depth(d + 1);
        leaf_total++;
        return ST_OK;
      end
      n = c - 1;
      d++;
      i--;
    end
  endfunction

  // Follow the key; at the first missing child head for the nearest edge leaf
  function automatic logic [1:0] trie_nearest(logic [KeyW-1:0] k, output int unsigned hit);
    int unsigned n, c;
    int mode;
    bit b, pref;
    hit = 0;
    if (leaf_total == 0) return ST_EMPTY;
    n = root_node;
    mode = 0;
    for (int i = KeyW - 1; i >= -1; i--) begin
      if (n >= nodes_used) return ST_EMPTY;
      if (is_leaf[n]) begin
        hit = n;
        return ST_OK;
      end
      if (i < 0) return ST_EMPTY;
      if (mode == 0) begin
        b = k[i];
        c = b ? link_hi[n] : link_lo[n];
        if (c == 0) begin
          c = b ? link_lo[n] : link_hi[n];
          mode = b ? 2 : 1;
        end
      end else begin
        pref = (mode == 2);
        c = pref ? link_hi[n] : link_lo[n];
        if (c == 0) c = pref ? link_lo[n] : link_hi[n];
      end
      if (c == 0) return ST_EMPTY;
      n = c - 1;
    end
    return ST_EMPTY;
  endfunction

  function automatic out_word_t trie_apply(in_word_t w);
    out_word_t r;
    int unsigned hit;
    r = '0;
    if (w.command == CMD_INSERT) begin
      r.status = trie_insert(w.key, w.value);
    end else begin
      r.status = trie_nearest(w.key, hit);
      if (r.status == ST_OK) begin
        r.match_key = node_key[hit];
        r.match_value = node_val[hit];
      end
    end
    r.leaf_count = leaf_total[LeafCntW-1:0];
    r.internal_count = inner_total[InnerCntW-1:0];
    r.tree_height = depth_max[HeightW-1:0];
    return r;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t: %s mismatch: got %0h want %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // Predict on each accepted word, compare each result strobe
  always @(posedge clk) begin
    out_word_t want;
    if (rst_n) begin
      if (start && !busy) trie_replies.push_back(trie_apply(in_word));
      if (out_valid) begin
        if (trie_replies.size() == 0) begin
          report("unexpected result", 64'(out_word.status), 64'd0);
        end else begin
          want = trie_replies.pop_front();
          if (out_word.status !== want.status)
            report("status", 64'(out_word.status), 64'(want.status));
          if (out_word.match_key !== want.match_key)
            report("match_key", 64'(out_word.match_key), 64'(want.match_key));
          if (out_word.match_value !== want.match_value)
            report("match_value", 64'(out_word.match_value), 64'(want.match_value));
          if (out_word.leaf_count !== want.leaf_count)
            report("leaf_count", 64'(out_word.leaf_count), 64'(want.leaf_count));
          if (out_word.internal_count !== want.internal_count)
            report("internal_count", 64'(out_word.internal_count),
                   64'(want.internal_count));
          if (out_word.tree_height !== want.tree_height)
            report("tree_height", 64'(out_word.tree_height), 64'(want.tree_height));
        end
      end
      replies_owed = trie_replies.size();
    end
  end

endmodule

FILE: dv/binary_trie_insert_nearest_search_unit_test.sv
`timescale 1ns / 1ps

module binary_trie_insert_nearest_search_unit_test;
  import btins_pkg::*;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_word_t  in_word;
  logic      out_valid;
  out_word_t out_word;
  int        mismatches;
  int        replies_owed;

  int unsigned      idle_pct;
  logic [KeyW-1:0]  known_keys[$];

  binary_trie_insert_nearest_search_unit u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_word (out_word)
  );

  binary_trie_insert_nearest_search_unit_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_word     (in_word),
    .out_valid   (out_valid),
    .out_word    (out_word),
    .mismatches  (mismatches),
    .replies_owed(replies_owed)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Hold the word until the block takes it; start stays high into the next word unless an idle gap is drawn
  task automatic send_word(logic cmd, logic [KeyW-1:0] k, logic [ValW-1:0] v);
    int gap;
    gap = 0;
    while ($urandom_range(99, 0) < idle_pct && gap < 12) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_word <= '{command: cmd, key: k, value: v};
    if (cmd == CMD_INSERT) known_keys.push_back(k);
    do @(posedge clk); while (busy);
  endtask

  // Mix fresh keys with near neighbors and repeats of stored keys
  function automatic logic [KeyW-1:0] pick_key();
    logic [KeyW-1:0] k;
    int unsigned sel;
    sel = $urandom_range(99, 0);
    if (known_keys.size() == 0 || sel < 35) return $urandom();
    k = known_keys[$urandom_range(known_keys.size() - 1, 0)];
    if (sel < 60) return k ^ (32'h1 << $urandom_range(31, 0));
    if (sel < 80) return k ^ ($urandom() >> $urandom_range(31, 4));
    return k;
  endfunction

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_word = '0;
    idle_pct = 29;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty search, extremes, duplicates, deepest split
    send_word(CMD_SEARCH, 32'h0, 32'h0);
    send_word(CMD_INSERT, 32'h0, 32'hFFFF_FFFF);
    send_word(CMD_SEARCH, 32'hFFFF_FFFF, 32'h0);
    send_word(CMD_INSERT, 32'hFFFF_FFFF, 32'h0);
    send_word(CMD_INSERT, 32'h0, 32'h1234_5678);
    send_word(CMD_INSERT, 32'h1, 32'hA5A5_A5A5);
    send_word(CMD_INSERT, 32'h1, 32'h0);
    send_word(CMD_INSERT, 32'hFFFF_FFFE, 32'h5A5A_5A5A);
    send_word(CMD_SEARCH, 32'h8000_0000, 32'hFFFF_FFFF);
    send_word(CMD_SEARCH, 32'h7FFF_FFFF, 32'h0);
    send_word(CMD_SEARCH, 32'h1, 32'h0);
    send_word(CMD_SEARCH, 32'h2, 32'h0);
    send_word(CMD_SEARCH, 32'hFFFF_FFFD, 32'h0);
    send_word(CMD_INSERT, 32'h8000_0000, 32'h8000_0001);
    send_word(CMD_SEARCH, 32'hC000_0000, 32'h0);

    // random: three idle profiles
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 29 : (ph == 1) ? 58 : 0;
      for (int n = 0; n < 415; n++) begin
        send_word(($urandom_range(99, 0) < 55) ? CMD_INSERT : CMD_SEARCH,
                  pick_key(), $urandom());
      end
    end
    start <= 1'b0;

    // drain outstanding results, then let the block settle
    while (replies_owed != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0) begin
      $display("binary_trie_insert_nearest_search_unit_test OK");
    end else begin
      $display("binary_trie_insert_nearest_search_unit_test NOT OK");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("binary_trie_insert_nearest_search_unit_test NOT OK");
    $finish;
  end

endmodule
